// ===== hw/rtl/mi3inv_pkg.sv =====
`timescale 1ns / 1ps
package mi3inv_pkg;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int ADJ_W  = 33;
  localparam int CMAG_W = 32;
  localparam int DET_W  = 49;
  localparam int MAG_W  = 48;
  localparam int THR_W  = 40;
  localparam int QBITS  = 33;
  localparam int OUT_W  = 32;
  localparam int OUT_FRAC_BITS = 16;
  localparam logic [THR_W-1:0] THR_RESET = 40'd687195;
  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [ELEM_W-1:0] in_r1c1;
    logic signed [ELEM_W-1:0] in_r1c2;
    logic signed [ELEM_W-1:0] in_r1c3;
    logic signed [ELEM_W-1:0] in_r2c1;
    logic signed [ELEM_W-1:0] in_r2c2;
    logic signed [ELEM_W-1:0] in_r2c3;
    logic signed [ELEM_W-1:0] in_r3c1;
    logic signed [ELEM_W-1:0] in_r3c2;
    logic signed [ELEM_W-1:0] in_r3c3;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv_r1c1;
    logic signed [OUT_W-1:0] inv_r1c2;
    logic signed [OUT_W-1:0] inv_r1c3;
    logic signed [OUT_W-1:0] inv_r2c1;
    logic signed [OUT_W-1:0] inv_r2c2;
    logic signed [OUT_W-1:0] inv_r2c3;
    logic signed [OUT_W-1:0] inv_r3c1;
    logic signed [OUT_W-1:0] inv_r3c2;
    logic signed [OUT_W-1:0] inv_r3c3;
    logic                    singular;
  } out_item_t;

  typedef struct packed {
    logic [8:0][CMAG_W-1:0] cmag;
    logic [8:0]             neg;
    logic [MAG_W-1:0]       den;
    logic                   singular;
  } q_item_t;

endpackage

// ===== hw/rtl/mi3inv_front.sv =====
`timescale 1ns / 1ps
module mi3inv_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  mi3inv_pkg::in_item_t                in_data,
  input  logic [mi3inv_pkg::THR_W-1:0]        thr,
  output logic                                push,
  output mi3inv_pkg::q_item_t                 push_data
);

  localparam int EW = mi3inv_pkg::ELEM_W;
  localparam int PW = mi3inv_pkg::PROD_W;
  localparam int AW = mi3inv_pkg::ADJ_W;
  localparam int CW = mi3inv_pkg::CMAG_W;
  localparam int DW = mi3inv_pkg::DET_W;
  localparam int MW = mi3inv_pkg::MAG_W;

  logic [4:0] vld_r;
  mi3inv_pkg::in_item_t m_r;
  logic signed [PW-1:0] p_r [18];
  logic signed [EW-1:0] abc2_r [3];
  logic signed [EW-1:0] abc3_r [3];
  logic signed [AW-1:0] adj_r [9];
  logic signed [DW-1:0] dp_r [3];
  logic [8:0][CW-1:0] cmag3_r, cmag4_r;
  logic [8:0] aneg3_r, aneg4_r;
  logic signed [DW-1:0] det_r;
  logic [DW-1:0] det_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    m_r <= in_data;
    p_r[0]  <= m_r.in_r2c2 * m_r.in_r3c3;
    p_r[1]  <= m_r.in_r2c3 * m_r.in_r3c2;
    p_r[2]  <= m_r.in_r1c3 * m_r.in_r3c2;
    p_r[3]  <= m_r.in_r1c2 * m_r.in_r3c3;
    p_r[4]  <= m_r.in_r1c2 * m_r.in_r2c3;
    p_r[5]  <= m_r.in_r1c3 * m_r.in_r2c2;
    p_r[6]  <= m_r.in_r2c3 * m_r.in_r3c1;
    p_r[7]  <= m_r.in_r2c1 * m_r.in_r3c3;
    p_r[8]  <= m_r.in_r1c1 * m_r.in_r3c3;
    p_r[9]  <= m_r.in_r1c3 * m_r.in_r3c1;
    p_r[10] <= m_r.in_r1c3 * m_r.in_r2c1;
    p_r[11] <= m_r.in_r1c1 * m_r.in_r2c3;
    p_r[12] <= m_r.in_r2c1 * m_r.in_r3c2;
    p_r[13] <= m_r.in_r2c2 * m_r.in_r3c1;
    p_r[14] <= m_r.in_r1c2 * m_r.in_r3c1;
    p_r[15] <= m_r.in_r1c1 * m_r.in_r3c2;
    p_r[16] <= m_r.in_r1c1 * m_r.in_r2c2;
    p_r[17] <= m_r.in_r1c2 * m_r.in_r2c1;
    abc2_r[0] <= m_r.in_r1c1;
    abc2_r[1] <= m_r.in_r1c2;
    abc2_r[2] <= m_r.in_r1c3;
    abc3_r <= abc2_r;
    for (int i = 0; i < 9; i++) begin
      adj_r[i] <= AW'(p_r[2*i]) - AW'(p_r[2*i+1]);
    end
    dp_r[0] <= DW'(abc3_r[0]) * DW'(adj_r[0]);
    dp_r[1] <= DW'(abc3_r[1]) * DW'(adj_r[3]);
    dp_r[2] <= DW'(abc3_r[2]) * DW'(adj_r[6]);
    for (int i = 0; i < 9; i++) begin
      aneg3_r[i] <= adj_r[i][AW-1];
      cmag3_r[i] <= adj_r[i][AW-1] ? CW'(-adj_r[i]) : CW'(adj_r[i]);
    end
    aneg4_r <= aneg3_r;
    cmag4_r <= cmag3_r;
    det_r <= dp_r[0] + dp_r[1] + dp_r[2];
  end

  always_comb begin
    det_abs = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    push = vld_r[4];
    push_data.cmag = cmag4_r;
    push_data.neg = aneg4_r ^ {9{det_r[DW-1]}};
    push_data.den = det_abs[MW-1:0];
    push_data.singular = (det_abs[MW-1:0] <= MW'(thr));
  end

endmodule

// ===== hw/rtl/mi3inv_queue.sv =====
`timescale 1ns / 1ps
module mi3inv_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mi3inv_pkg::q_item_t  push_data,
  output logic                 pop,
  output mi3inv_pkg::q_item_t  pop_data,
  output logic                 full
);

  mi3inv_pkg::q_item_t mem_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign pop = (count_r != 2'd0);
  assign full = (count_r == 2'd2);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mi3inv_div_lane.sv =====
`timescale 1ns / 1ps
module mi3inv_div_lane #(
  parameter int SHIFT = 28
) (
  input  logic                               clk,
  input  logic [mi3inv_pkg::CMAG_W-1:0]      cmag,
  input  logic [mi3inv_pkg::MAG_W-1:0]       den,
  input  logic                               neg,
  output logic [mi3inv_pkg::OUT_W-1:0]       quot
);

  localparam int QB = mi3inv_pkg::QBITS;
  localparam int W  = mi3inv_pkg::MAG_W + QB;

  logic [W-1:0]  rem_r [QB+1];
  logic [W-1:0]  den_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];
  logic [W-1:0]  num;
  logic [QB-1:0] qf;

  assign num = W'(cmag) << SHIFT;

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= W'(den);
    q_r[0] <= '0;
    neg_r[0] <= neg;
    ovf_r[0] <= ((num >> QB) >= W'(den));
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [W-1:0] trial;
    assign trial = den_r[k-1] << (QB - k);
    always_ff @(posedge clk) begin
      den_r[k] <= den_r[k-1];
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
      if (rem_r[k-1] >= trial) begin
        rem_r[k] <= rem_r[k-1] - trial;
        q_r[k] <= q_r[k-1] | (QB'(1) << (QB - k));
      end else begin
        rem_r[k] <= rem_r[k-1];
        q_r[k] <= q_r[k-1];
      end
    end
  end

  always_comb begin
    qf = q_r[QB];
    if (!neg_r[QB]) begin
      quot = (ovf_r[QB] || qf > QB'(mi3inv_pkg::SAT_POS)) ? mi3inv_pkg::SAT_POS : qf[31:0];
    end else begin
      quot = (ovf_r[QB] || qf > QB'(mi3inv_pkg::SAT_NEG)) ? mi3inv_pkg::SAT_NEG : 32'(-qf);
    end
  end

endmodule

// ===== hw/rtl/mi3inv_back.sv =====
`timescale 1ns / 1ps
module mi3inv_back #(
  parameter int SHIFT = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pop,
  input  mi3inv_pkg::q_item_t     pop_data,
  output logic                    out_valid,
  output mi3inv_pkg::out_item_t   out_data
);

  localparam int QB = mi3inv_pkg::QBITS;

  logic [QB:0] vld_r;
  logic [QB:0] sing_r;
  logic [8:0][mi3inv_pkg::OUT_W-1:0] quot;
  logic out_valid_r;
  mi3inv_pkg::out_item_t out_data_r, out_data_nxt;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3inv_div_lane #(.SHIFT(SHIFT)) u_lane (
      .clk  (clk),
      .cmag (pop_data.cmag[i]),
      .den  (pop_data.den),
      .neg  (pop_data.neg[i]),
      .quot (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[QB-1:0], pop};
      out_valid_r <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    sing_r <= {sing_r[QB-1:0], pop_data.singular};
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt.singular = sing_r[QB];
    if (!sing_r[QB]) begin
      out_data_nxt.inv_r1c1 = quot[0];
      out_data_nxt.inv_r1c2 = quot[1];
      out_data_nxt.inv_r1c3 = quot[2];
      out_data_nxt.inv_r2c1 = quot[3];
      out_data_nxt.inv_r2c2 = quot[4];
      out_data_nxt.inv_r2c3 = quot[5];
      out_data_nxt.inv_r3c1 = quot[6];
      out_data_nxt.inv_r3c2 = quot[7];
      out_data_nxt.inv_r3c3 = quot[8];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// ===== hw/rtl/matrix_inverse_3x3_core.sv =====
// Throughput: one matrix per cycle when busy is low; the 33-stage
// restoring divider (one quotient bit per stage, nine lanes) and the
// five-stage cofactor front are fully pipelined, so busy stays low
// in normal operation.
// Reset: synchronous, active low; clears pipeline valids and loads the
// default threshold. The receiver cannot stall results.
`timescale 1ns / 1ps
module matrix_inverse_3x3_core #(
  parameter int INPUT_FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  mi3inv_pkg::in_item_t              in_data,
  output logic                              out_valid,
  output mi3inv_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  logic [mi3inv_pkg::THR_W-1:0]      cfg_wdata
);

  logic [mi3inv_pkg::THR_W-1:0] det_threshold_r;
  logic push, pop, full;
  mi3inv_pkg::q_item_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_threshold_r <= mi3inv_pkg::THR_RESET;
    end else if (cfg_we) begin
      det_threshold_r <= cfg_wdata;
    end
  end

  assign busy = full;

  mi3inv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .thr       (det_threshold_r),
    .push      (push),
    .push_data (push_data)
  );

  mi3inv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full)
  );

  mi3inv_back #(.SHIFT(mi3inv_pkg::OUT_FRAC_BITS + INPUT_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_queue_never_full: assert property (@(posedge clk) disable iff (!rst_n) !full)
    else $error("queue filled up");
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |-> (out_data.inv_r1c1 == 0 && out_data.inv_r2c2 == 0
      && out_data.inv_r3c3 == 0 && out_data.inv_r1c3 == 0 && out_data.inv_r3c1 == 0))
    else $error("singular result with nonzero elements");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##41 out_valid)
    else $error("result missing after transfer");
`endif

endmodule

// ===== tb/matrix_inverse_3x3_checker.sv =====
`timescale 1ns / 1ps
module matrix_inverse_3x3_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  mi3inv_pkg::in_item_t             in_data,
  input  logic                             out_valid,
  input  mi3inv_pkg::out_item_t            out_data,
  input  logic                             cfg_we,
  input  logic [mi3inv_pkg::THR_W-1:0]     cfg_wdata,
  output int                               errors,
  output int                               pending,
  output int                               checked,
  output int                               singular_seen,
  output int                               saturated_seen
);

  localparam int FRAC_IN = 12;
  localparam int OW = mi3inv_pkg::OUT_W;

  logic [mi3inv_pkg::THR_W-1:0] threshold;
  mi3inv_pkg::out_item_t        inverse_q[$];

  function automatic logic [OW-1:0] quot_sat(longint cof, longint det);
    bit neg;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    neg = (cof < 0) != (det < 0);
    num = longint'(cof < 0 ? -cof : cof);
    num = num << (mi3inv_pkg::OUT_FRAC_BITS + FRAC_IN);
    den = longint'(det < 0 ? -det : det);
    q = num / den;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[OW-1:0];
    end
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    q = 64'd0 - q;
    return q[OW-1:0];
  endfunction

  function automatic mi3inv_pkg::out_item_t inverse_of(mi3inv_pkg::in_item_t m,
                                                       logic [mi3inv_pkg::THR_W-1:0] thr);
    longint a, b, c, d, e, f, g, h, k, det;
    longint unsigned det_mag;
    longint adj[9];
    logic [OW-1:0] r[9];
    mi3inv_pkg::out_item_t o;
    a = m.in_r1c1; b = m.in_r1c2; c = m.in_r1c3;
    d = m.in_r2c1; e = m.in_r2c2; f = m.in_r2c3;
    g = m.in_r3c1; h = m.in_r3c2; k = m.in_r3c3;
    adj[0] = e * k - f * h;
    adj[1] = -(b * k - c * h);
    adj[2] = b * f - c * e;
    adj[3] = -(d * k - f * g);
    adj[4] = a * k - c * g;
    adj[5] = -(a * f - c * d);
    adj[6] = d * h - e * g;
    adj[7] = -(a * h - b * g);
    adj[8] = a * e - b * d;
    det = a * adj[0] + b * adj[3] + c * adj[6];
    det_mag = longint'(det < 0 ? -det : det);
    o = '0;
    if (det_mag <= longint'({24'd0, thr})) begin
      o.singular = 1'b1;
      return o;
    end
    for (int i = 0; i < 9; i++) r[i] = quot_sat(adj[i], det);
    o.inv_r1c1 = r[0]; o.inv_r1c2 = r[1]; o.inv_r1c3 = r[2];
    o.inv_r2c1 = r[3]; o.inv_r2c2 = r[4]; o.inv_r2c3 = r[5];
    o.inv_r3c1 = r[6]; o.inv_r3c2 = r[7]; o.inv_r3c3 = r[8];
    return o;
  endfunction

  function automatic void unpack_inv(mi3inv_pkg::out_item_t o, output logic [OW-1:0] v[9]);
    v[0] = o.inv_r1c1; v[1] = o.inv_r1c2; v[2] = o.inv_r1c3;
    v[3] = o.inv_r2c1; v[4] = o.inv_r2c2; v[5] = o.inv_r2c3;
    v[6] = o.inv_r3c1; v[7] = o.inv_r3c2; v[8] = o.inv_r3c3;
  endfunction

  task automatic report_mismatch(string what, logic [OW-1:0] got,
                                 logic [OW-1:0] want);
    errors++;
    if (errors <= 40)
      $display("ERROR t=%0t result %0d %s: got %h, want %h",
               $realtime, checked, what, got, want);
  endtask

  always @(posedge clk) begin
    logic [OW-1:0] gv[9];
    logic [OW-1:0] wv[9];
    mi3inv_pkg::out_item_t want;
    int sat_count;
    if (!rst_n) begin
      threshold <= mi3inv_pkg::THR_RESET;
      inverse_q.delete();
      errors <= 0;
      checked <= 0;
      singular_seen <= 0;
      saturated_seen <= 0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (start && !busy) inverse_q.push_back(inverse_of(in_data, threshold));
      if (out_valid) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected transfer", '0, '0);
        end else begin
          want = inverse_q.pop_front();
          unpack_inv(out_data, gv);
          unpack_inv(want, wv);
          sat_count = 0;
          for (int i = 0; i < 9; i++) begin
            if (gv[i] !== wv[i])
              report_mismatch($sformatf("inv_r%0dc%0d", i / 3 + 1, i % 3 + 1),
                              gv[i], wv[i]);
            if (wv[i] == mi3inv_pkg::SAT_POS || wv[i] == mi3inv_pkg::SAT_NEG)
              sat_count++;
          end
          saturated_seen <= saturated_seen + sat_count;
          if (out_data.singular !== want.singular)
            report_mismatch("singular", {{(OW-1){1'b0}}, out_data.singular},
                            {{(OW-1){1'b0}}, want.singular});
          if (want.singular) singular_seen <= singular_seen + 1;
        end
        checked <= checked + 1;
      end
    end
  end

  assign pending = inverse_q.size();

endmodule

// ===== tb/matrix_inverse_3x3_core_tb.sv =====
`timescale 1ns / 1ps
module matrix_inverse_3x3_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN = 45;
  localparam int IN_BITS = $bits(mi3inv_pkg::in_item_t);
  localparam int EW = mi3inv_pkg::ELEM_W;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  mi3inv_pkg::in_item_t          in_data;
  logic                          out_valid;
  mi3inv_pkg::out_item_t         out_data;
  logic                          cfg_we;
  logic [mi3inv_pkg::THR_W-1:0]  cfg_wdata;
  int                            errors, pending, checked, singular_seen, saturated_seen;
  int                            cycles = 0;
  int                            sent;

  matrix_inverse_3x3_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  matrix_inverse_3x3_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .checked(checked),
    .singular_seen(singular_seen), .saturated_seen(saturated_seen)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic mi3inv_pkg::in_item_t mat(int a, int b, int c, int d, int e, int f,
                                               int g, int h, int k);
    mi3inv_pkg::in_item_t m;
    m.in_r1c1 = EW'(a); m.in_r1c2 = EW'(b); m.in_r1c3 = EW'(c);
    m.in_r2c1 = EW'(d); m.in_r2c2 = EW'(e); m.in_r2c3 = EW'(f);
    m.in_r3c1 = EW'(g); m.in_r3c2 = EW'(h); m.in_r3c3 = EW'(k);
    return m;
  endfunction

  function automatic int small_elem();
    return $signed($urandom_range(0, 16383)) - 8192;
  endfunction

  function automatic mi3inv_pkg::in_item_t random_matrix();
    mi3inv_pkg::in_item_t m;
    int sel;
    int s;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      m = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (sel < 7) begin
      m = mat(small_elem(), small_elem(), small_elem(), small_elem(), small_elem(),
              small_elem(), small_elem(), small_elem(), small_elem());
    end else if (sel < 9) begin
      m = mat(small_elem(), small_elem(), small_elem(), small_elem(), small_elem(),
              small_elem(), 0, 0, 0);
      s = $urandom_range(0, 3);
      m.in_r3c1 = EW'(m.in_r1c1 + s);
      m.in_r3c2 = m.in_r1c2;
      m.in_r3c3 = EW'(m.in_r1c3 - s);
    end else begin
      m = mat($urandom_range(1, 64), 0, 0, 0, $urandom_range(1, 64), 0,
              0, 0, $urandom_range(1, 64));
      m.in_r1c2 = EW'(small_elem());
    end
    return m;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_matrix(mi3inv_pkg::in_item_t m, int gap);
    start <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (busy);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_threshold(logic [mi3inv_pkg::THR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, bit no_gaps);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_idle();
      send_matrix(random_matrix(), no_gaps ? 0 : gap_len());
    end
  endtask

  initial begin
    mi3inv_pkg::in_item_t directed[$];
    sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    random_phase(400, 1'b0);
    wait_idle();

    write_threshold('0);
    directed.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mat(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
    directed.push_back(mat(-4096, 0, 0, 0, -4096, 0, 0, 0, -4096));
    directed.push_back(mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(mat(1, 32767, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(mat(1, -32768, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(mat(1, 0, 32767, 0, -1, 32767, 0, 0, 1));
    directed.push_back(mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    directed.push_back(mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    directed.push_back(mat(-32768, 32767, 0, 0, -32768, 32767, 32767, 0, -32768));
    directed.push_back(mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(mat(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768));
    directed.push_back(mat(1, 2, 3, 2, 4, 6, 7, 8, 9));
    directed.push_back(mat(0, 4096, 0, 4096, 0, 0, 0, 0, 4096));
    directed.push_back(mat(8192, 4096, 0, 4096, 8192, 4096, 0, 4096, 8192));
    directed.push_back(mat(-1, 0, 0, 0, -1, 0, 0, 0, -1));
    directed.push_back(mat(32767, -32768, 1, -32768, 32767, -1, 1, -1, 32767));
    foreach (directed[i]) send_matrix(directed[i], i % 3);
    random_phase(400, 1'b1);
    wait_idle();

    write_threshold({mi3inv_pkg::THR_W{1'b1}});
    foreach (directed[i]) send_matrix(directed[i], 0);
    random_phase(400, 1'b0);
    wait_idle();

    write_threshold({8'($urandom_range(0, 255)), $urandom});
    random_phase(400, 1'b0);
    wait_idle();

    write_threshold(mi3inv_pkg::THR_RESET);
    random_phase(400, 1'b0);
    wait_idle();

    $display("Sent %0d matrices over five threshold settings, checked %0d results",
             sent, checked);
    $display("Singular results %0d, saturated elements %0d", singular_seen, saturated_seen);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== matrix_inverse_3x3_core.f =====
hw/rtl/mi3inv_pkg.sv
hw/rtl/mi3inv_front.sv
hw/rtl/mi3inv_queue.sv
hw/rtl/mi3inv_div_lane.sv
hw/rtl/mi3inv_back.sv
hw/rtl/matrix_inverse_3x3_core.sv
tb/matrix_inverse_3x3_checker.sv
tb/matrix_inverse_3x3_core_tb.sv
